>>> design/ppls_pkg.sv
// shared types and constants for the phong point-light shader
// no dependencies; every other design file imports this package
package ppls_pkg;

  localparam int unsigned LANE_W    = 16;
  localparam int unsigned VEC_W     = 3 * LANE_W;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned SHIN_W    = 8;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned D_W       = LANE_W + 1;
  localparam int unsigned SQ_W      = 32;
  localparam int unsigned LEN2_W    = SQ_W + 2;
  localparam int unsigned SQ_IN_W   = LEN2_W + 16;
  localparam int unsigned LEN_W     = SQ_IN_W / 2;
  localparam int unsigned Q_W       = 15;
  localparam int unsigned NUM_W     = 39;
  localparam int unsigned E_W       = 20;
  localparam int unsigned ST_W      = 16;
  localparam int unsigned PROD_W    = 2 * LANE_W;
  localparam int unsigned LDN_W     = PROD_W + 1;
  localparam int unsigned LDN16_W   = 21;
  localparam int unsigned M_W       = LDN_W + LANE_W + 1;
  localparam int unsigned R_W       = 34;
  localparam int unsigned RE_W      = R_W + LANE_W;
  localparam int unsigned RDE_W     = RE_W + 2;
  localparam int unsigned F_W       = 17;
  localparam int unsigned DT_W      = 25;
  localparam int unsigned DFR_W     = 26;
  localparam int unsigned SF_W      = 17;
  localparam int unsigned SFR_W     = 18;
  localparam int unsigned SUM_W     = 28;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned POW_STAGES = (1 << SHIN_W) - 1;

  localparam logic [LDN16_W-1:0] LDN16_CAP = LDN16_W'(1048576);
  localparam logic [F_W-1:0]     ONE_Q16   = F_W'(65536);

  typedef enum logic [0:0] {
    REG_LIGHT_POS   = 1'b0,
    REG_LIGHT_COLOR = 1'b1
  } reg_idx_e;

  // per-item data that rides along the whole pipe
  typedef struct packed {
    logic [VEC_W-1:0]          nv;
    logic [VEC_W-1:0]          ev;
    logic [2:0][E_W-1:0]       amb_t;
    logic [2:0][E_W-1:0]       de;
    logic [2:0][ST_W-1:0]      st;
    logic [FRAC_W-1:0]         frac;
    logic [SHIN_W-1:0]         shin;
  } shade_t;

  typedef struct packed {
    logic [2:0][LANE_W-1:0] mag;
    logic [2:0]             dneg;
    shade_t                 sh;
  } sq_side_t;

  typedef struct packed {
    logic [2:0]  dneg;
    logic        len_zero;
    shade_t      sh;
  } dv_side_t;

  typedef struct packed {
    logic                lit;
    logic [LDN16_W-1:0]  ldn16;
    shade_t              sh;
  } pw_side_t;

endpackage

>>> design/ppls_in_if.sv
// input channel of the shader: valid/ready plus one hit beat
// depends on ppls_pkg
interface ppls_in_if import ppls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VEC_W-1:0]    surface_color;
  logic [VEC_W-1:0]    hit_point;
  logic [VEC_W-1:0]    eye_vector;
  logic [VEC_W-1:0]    normal_vector;
  logic [COEF_W-1:0]   ambient_coef;
  logic [COEF_W-1:0]   diffuse_coef;
  logic [COEF_W-1:0]   specular_coef;
  logic [SHIN_W-1:0]   shininess;
  logic [FRAC_W-1:0]   light_fraction;

  modport source (
    output valid, surface_color, hit_point, eye_vector, normal_vector,
           ambient_coef, diffuse_coef, specular_coef, shininess, light_fraction,
    input  ready
  );
  modport sink (
    input  valid, surface_color, hit_point, eye_vector, normal_vector,
           ambient_coef, diffuse_coef, specular_coef, shininess, light_fraction,
    output ready
  );
endinterface

>>> design/ppls_out_if.sv
// output channel of the shader: valid/ready plus one rgb beat
// depends on ppls_pkg
interface ppls_out_if import ppls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] out_red;
  logic [OUT_W-1:0] out_green;
  logic [OUT_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

>>> design/ppls_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on ppls_pkg
module ppls_isqrt import ppls_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [SQ_IN_W-1:0] x_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [LEN_W-1:0]   root_o,
  output logic [SIDE_W-1:0]  side_o
);
  localparam int unsigned RW = SQ_IN_W + 2;

  logic              v_q    [LEN_W];
  logic [RW-1:0]     rem_q  [LEN_W];
  logic [LEN_W-1:0]  root_q [LEN_W];
  logic [SIDE_W-1:0] side_q [LEN_W];

  for (genvar s = 0; s < LEN_W; s++) begin : g_stage
    localparam int unsigned B = LEN_W - 1 - s;
    logic              v_in;
    logic [RW-1:0]     rem_in;
    logic [RW-1:0]     trial;
    logic [LEN_W-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = RW'(x_i);
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // (r + 2^b)^2 - r^2
    assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        if (rem_in >= trial) begin
          rem_q[s]  <= rem_in - trial;
          root_q[s] <= root_in | (LEN_W'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[LEN_W-1];
  assign root_o  = root_q[LEN_W-1];
  assign side_o  = side_q[LEN_W-1];
endmodule

>>> design/ppls_div.sv
// pipelined restoring divider, three lanes sharing one divisor
// depends on ppls_pkg
module ppls_div import ppls_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2:0][NUM_W-1:0] num_i,
  input  logic [LEN_W-1:0]      den_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [2:0][Q_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]     side_o
);
  localparam int unsigned DW = NUM_W + 1;

  logic                  v_q    [Q_W];
  logic [2:0][DW-1:0]    rem_q  [Q_W];
  logic [2:0][Q_W-1:0]   quo_q  [Q_W];
  logic [LEN_W-1:0]      den_q  [Q_W];
  logic [SIDE_W-1:0]     side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int unsigned B = Q_W - 1 - s;
    logic                v_in;
    logic [2:0][DW-1:0]  rem_in;
    logic [2:0][Q_W-1:0] quo_in;
    logic [LEN_W-1:0]    den_in;
    logic [SIDE_W-1:0]   side_in;
    logic [DW-1:0]       sub;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = {DW'(num_i[2]), DW'(num_i[1]), DW'(num_i[0])};
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign sub = DW'(den_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= sub) begin
            rem_q[s][l] <= rem_in[l] - sub;
            quo_q[s][l] <= quo_in[l] | (Q_W'(1) << B);
          end else begin
            rem_q[s][l] <= rem_in[l];
            quo_q[s][l] <= quo_in[l];
          end
        end
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];
endmodule

>>> design/ppls_pow.sv
// shininess power: one rounded q1.16 product per stage, skipped past the exponent
// depends on ppls_pkg
module ppls_pow import ppls_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [F_W-1:0]    base_i,
  input  logic [F_W-1:0]    factor_i,
  input  logic [SHIN_W-1:0] shin_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [F_W-1:0]    factor_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int unsigned PW = 2 * F_W;

  logic              v_q    [POW_STAGES];
  logic [F_W-1:0]    base_q [POW_STAGES];
  logic [F_W-1:0]    fac_q  [POW_STAGES];
  logic [SHIN_W-1:0] shin_q [POW_STAGES];
  logic [SIDE_W-1:0] side_q [POW_STAGES];

  for (genvar s = 0; s < POW_STAGES; s++) begin : g_stage
    logic              v_in;
    logic [F_W-1:0]    base_in;
    logic [F_W-1:0]    fac_in;
    logic [SHIN_W-1:0] shin_in;
    logic [SIDE_W-1:0] side_in;
    logic [PW-1:0]     prod;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign base_in = base_i;
      assign fac_in  = factor_i;
      assign shin_in = shin_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign base_in = base_q[s-1];
      assign fac_in  = fac_q[s-1];
      assign shin_in = shin_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign prod = PW'(fac_in) * PW'(base_in) + PW'(32768);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        base_q[s] <= base_in;
        shin_q[s] <= shin_in;
        side_q[s] <= side_in;
        if (SHIN_W'(s) < shin_in) begin
          fac_q[s] <= F_W'(prod >> 16);
        end else begin
          fac_q[s] <= fac_in;
        end
      end
    end
  end

  assign valid_o  = v_q[POW_STAGES-1];
  assign factor_o = fac_q[POW_STAGES-1];
  assign side_o   = side_q[POW_STAGES-1];

  a_factor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> factor_o <= ONE_Q16)
    else $error("power factor above one");
endmodule

>>> design/phong_point_light_shader.sv
// phong point-light shader: throughput one beat per cycle; the pipe stalls
// as a whole only when the output skid register is full, so the 255-stage
// shininess chain sets the depth
// reset clears all valid bits and the light registers; payload is not reset
// depends on ppls_pkg, ppls_in_if, ppls_out_if, ppls_isqrt, ppls_div, ppls_pow
module phong_point_light_shader import ppls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppls_in_if.sink           in_if,
  ppls_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // configuration registers, one per 8-byte slot
  // ---------------------------------------------------------------------------
  logic [VEC_W-1:0] lpos_q, lcol_q;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpos_q <= '0;
      lcol_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_LIGHT_POS:   lpos_q <= pwdata[VEC_W-1:0];
        REG_LIGHT_COLOR: lcol_q <= pwdata[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LIGHT_POS:   prdata = DATA_W'(lpos_q);
      REG_LIGHT_COLOR: prdata = DATA_W'(lcol_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // global pipe enable: everything moves unless the skid register holds a beat
  // ---------------------------------------------------------------------------
  logic en;
  logic out_v_q, skid_v_q;

  assign en          = !skid_v_q;
  assign in_if.ready = en;

  // ---------------------------------------------------------------------------
  // stage a: light vector components and light-scaled colors
  // ---------------------------------------------------------------------------
  logic                    a_v_q;
  logic signed [D_W-1:0]   a_d_d   [3], a_d_q [3];
  logic [E_W-1:0]          a_e_d   [3], a_e_q [3];
  logic [ST_W-1:0]         a_st_d  [3], a_st_q [3];
  logic [VEC_W-1:0]        a_nv_q, a_ev_q;
  logic [COEF_W-1:0]       a_amb_q, a_dif_q;
  logic [FRAC_W-1:0]       a_frac_q;
  logic [SHIN_W-1:0]       a_shin_q;

  always_comb begin
    logic [LANE_W-1:0] lp, hp, sc, lc;
    for (int l = 0; l < 3; l++) begin
      lp = lpos_q[LANE_W*l +: LANE_W];
      hp = in_if.hit_point[LANE_W*l +: LANE_W];
      sc = in_if.surface_color[LANE_W*l +: LANE_W];
      lc = lcol_q[LANE_W*l +: LANE_W];
      a_d_d[l]  = $signed({lp[LANE_W-1], lp}) - $signed({hp[LANE_W-1], hp});
      // surface times light, rounded back to q.12
      a_e_d[l]  = E_W'((32'(sc) * 32'(lc) + 32'd2048) >> 12);
      // light times specular coefficient, rounded q.16
      a_st_d[l] = ST_W'((32'(lc) * 32'(in_if.specular_coef) + 32'd32768) >> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_d_q    <= a_d_d;
      a_e_q    <= a_e_d;
      a_st_q   <= a_st_d;
      a_nv_q   <= in_if.normal_vector;
      a_ev_q   <= in_if.eye_vector;
      a_amb_q  <= in_if.ambient_coef;
      a_dif_q  <= in_if.diffuse_coef;
      a_frac_q <= in_if.light_fraction;
      a_shin_q <= in_if.shininess;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: squared components, magnitudes, ambient and diffuse color terms
  // ---------------------------------------------------------------------------
  logic              b_v_q;
  logic [SQ_W-1:0]   b_sq_d [3], b_sq_q [3];
  sq_side_t          b_side_d, b_side_q;

  always_comb begin
    logic signed [2*D_W-1:0] sq;
    logic signed [D_W-1:0]   neg;
    b_side_d.sh.nv   = a_nv_q;
    b_side_d.sh.ev   = a_ev_q;
    b_side_d.sh.frac = a_frac_q;
    b_side_d.sh.shin = a_shin_q;
    for (int l = 0; l < 3; l++) begin
      sq  = a_d_q[l] * a_d_q[l];
      neg = -a_d_q[l];
      b_sq_d[l]           = sq[SQ_W-1:0];
      b_side_d.dneg[l]    = a_d_q[l][D_W-1];
      b_side_d.mag[l]     = a_d_q[l][D_W-1] ? neg[LANE_W-1:0] : a_d_q[l][LANE_W-1:0];
      b_side_d.sh.amb_t[l] = E_W'((37'(a_e_q[l]) * 37'(a_amb_q) + 37'd32768) >> 16);
      b_side_d.sh.de[l]    = E_W'((37'(a_e_q[l]) * 37'(a_dif_q) + 37'd32768) >> 16);
      b_side_d.sh.st[l]    = a_st_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_sq_q   <= b_sq_d;
      b_side_q <= b_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: squared length
  // ---------------------------------------------------------------------------
  logic              c_v_q;
  logic [LEN2_W-1:0] c_len2_q;
  sq_side_t          c_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_len2_q <= LEN2_W'(b_sq_q[0]) + LEN2_W'(b_sq_q[1]) + LEN2_W'(b_sq_q[2]);
      c_side_q <= b_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // length in units of 2^-8: floor sqrt of len2 * 2^16
  // ---------------------------------------------------------------------------
  logic             sq_v;
  logic [LEN_W-1:0] sq_len;
  sq_side_t         sq_side;

  ppls_isqrt #(.SIDE_W($bits(sq_side_t))) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .x_i     ({c_len2_q, 16'd0}),
    .side_i  (c_side_q),
    .valid_o (sq_v),
    .root_o  (sq_len),
    .side_o  (sq_side)
  );

  // ---------------------------------------------------------------------------
  // normalize: |d| * 2^22 / len, rounded; the quotient never exceeds 2^14
  // ---------------------------------------------------------------------------
  logic [2:0][NUM_W-1:0] dv_num;
  dv_side_t              dv_side_in, dv_side;
  logic                  dv_v;
  logic [2:0][Q_W-1:0]   dv_quo;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv_num[l] = (NUM_W'(sq_side.mag[l]) << 22) + NUM_W'(sq_len >> 1);
    end
    dv_side_in.dneg     = sq_side.dneg;
    dv_side_in.len_zero = (sq_len == '0);
    dv_side_in.sh       = sq_side.sh;
  end

  ppls_div #(.SIDE_W($bits(dv_side_t))) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .num_i   (dv_num),
    .den_i   (sq_len),
    .side_i  (dv_side_in),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------------------
  // signed unit light vector, q1.14; light at the hit point gives zero
  // ---------------------------------------------------------------------------
  logic                     lv_v_q;
  logic signed [LANE_W-1:0] lv_d [3], lv_q [3];
  shade_t                   lv_sh_q;

  always_comb begin
    logic [LANE_W-1:0] qx;
    for (int l = 0; l < 3; l++) begin
      qx = LANE_W'(dv_quo[l]);
      if (dv_side.len_zero) begin
        lv_d[l] = '0;
      end else if (dv_side.dneg[l]) begin
        lv_d[l] = $signed(~qx + LANE_W'(1));
      end else begin
        lv_d[l] = $signed(qx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lv_q    <= lv_d;
      lv_sh_q <= dv_side.sh;
    end
  end

  // light . normal, per axis then summed
  logic                     pr_v_q;
  logic signed [PROD_W-1:0] pr_q [3];
  logic signed [LANE_W-1:0] pr_lv_q [3];
  shade_t                   pr_sh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pr_q[l] <= lv_q[l] * $signed(lv_sh_q.nv[LANE_W*l +: LANE_W]);
      end
      pr_lv_q <= lv_q;
      pr_sh_q <= lv_sh_q;
    end
  end

  logic                     ld_v_q;
  logic signed [LDN_W-1:0]  ldn_q;
  logic signed [LANE_W-1:0] ld_lv_q [3];
  shade_t                   ld_sh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ldn_q   <= LDN_W'(pr_q[0]) + LDN_W'(pr_q[1]) + LDN_W'(pr_q[2]);
      ld_lv_q <= pr_lv_q;
      ld_sh_q <= pr_sh_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage h: lit decision, diffuse dot (capped at 16.0), 2*ldn*n for reflection
  // ---------------------------------------------------------------------------
  logic                     h_v_q;
  logic                     lit_d, lit_q;
  logic [LDN16_W-1:0]       ldn16_d, ldn16_q;
  logic signed [M_W-1:0]    m_d [3], m_q [3];
  logic signed [LANE_W-1:0] h_lv_q [3];
  shade_t                   h_sh_q;

  always_comb begin
    logic [LDN_W-1:0]          rnd;
    logic signed [M_W-2:0]     p;
    lit_d = !ldn_q[LDN_W-1] && (ld_sh_q.frac != '0);
    rnd   = (LDN_W'(ldn_q) + LDN_W'(32)) >> 6;
    if (!lit_d) begin
      ldn16_d = '0;
    end else if (rnd > LDN_W'(LDN16_CAP)) begin
      ldn16_d = LDN16_CAP;
    end else begin
      ldn16_d = LDN16_W'(rnd);
    end
    for (int l = 0; l < 3; l++) begin
      p      = ldn_q * $signed(ld_sh_q.nv[LANE_W*l +: LANE_W]);
      m_d[l] = $signed({p, 1'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lit_q   <= lit_d;
      ldn16_q <= ldn16_d;
      m_q     <= m_d;
      h_lv_q  <= ld_lv_q;
      h_sh_q  <= ld_sh_q;
    end
  end

  // reflected vector r = -l + floor(2 ldn n / 2^16)
  logic                  i_v_q;
  logic signed [R_W-1:0] r_q [3];
  logic                  i_lit_q;
  logic [LDN16_W-1:0]    i_ldn16_q;
  shade_t                i_sh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        r_q[l] <= R_W'(m_q[l] >>> 16) - R_W'(h_lv_q[l]);
      end
      i_lit_q   <= lit_q;
      i_ldn16_q <= ldn16_q;
      i_sh_q    <= h_sh_q;
    end
  end

  // reflected . eye, per axis then summed
  logic                   j_v_q;
  logic signed [RE_W-1:0] re_q [3];
  logic                   j_lit_q;
  logic [LDN16_W-1:0]     j_ldn16_q;
  shade_t                 j_sh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        re_q[l] <= r_q[l] * $signed(i_sh_q.ev[LANE_W*l +: LANE_W]);
      end
      j_lit_q   <= i_lit_q;
      j_ldn16_q <= i_ldn16_q;
      j_sh_q    <= i_sh_q;
    end
  end

  logic                    k_v_q;
  logic signed [RDE_W-1:0] rde_q;
  logic                    k_lit_q;
  logic [LDN16_W-1:0]      k_ldn16_q;
  shade_t                  k_sh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rde_q     <= RDE_W'(re_q[0]) + RDE_W'(re_q[1]) + RDE_W'(re_q[2]);
      k_lit_q   <= j_lit_q;
      k_ldn16_q <= j_ldn16_q;
      k_sh_q    <= j_sh_q;
    end
  end

  // ---------------------------------------------------------------------------
  // specular base f in q1.16 (capped at one), then f^shininess
  // ---------------------------------------------------------------------------
  logic               spec_on;
  logic [RDE_W-1:0]   f_rnd;
  logic [F_W-1:0]     pw_base, pw_init;
  pw_side_t           pw_side_in, pw_side;
  logic               pw_v;
  logic [F_W-1:0]     pw_factor;

  always_comb begin
    spec_on = k_lit_q && !rde_q[RDE_W-1] && (rde_q != '0);
    f_rnd   = (RDE_W'(rde_q) + RDE_W'(32)) >> 6;
    if (!spec_on) begin
      pw_base = '0;
    end else if (f_rnd > RDE_W'(ONE_Q16)) begin
      pw_base = ONE_Q16;
    end else begin
      pw_base = F_W'(f_rnd);
    end
    pw_init          = spec_on ? ONE_Q16 : '0;
    pw_side_in.lit   = k_lit_q;
    pw_side_in.ldn16 = k_ldn16_q;
    pw_side_in.sh    = k_sh_q;
  end

  ppls_pow #(.SIDE_W($bits(pw_side_t))) u_pow (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (k_v_q),
    .base_i   (pw_base),
    .factor_i (pw_init),
    .shin_i   (k_sh_q.shin),
    .side_i   (pw_side_in),
    .valid_o  (pw_v),
    .factor_o (pw_factor),
    .side_o   (pw_side)
  );

  // ---------------------------------------------------------------------------
  // stage m: diffuse scaled by dot, specular scaled by power factor
  // ---------------------------------------------------------------------------
  logic             m_v_q;
  logic [DT_W-1:0]  dt_q [3];
  logic [SF_W-1:0]  sf_q [3];
  logic [E_W-1:0]   m_amb_q [3];
  logic [FRAC_W-1:0] m_frac_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        dt_q[l] <= DT_W'((42'(pw_side.sh.de[l]) * 42'(pw_side.ldn16) + 42'd32768) >> 16);
        sf_q[l] <= SF_W'((34'(pw_side.sh.st[l]) * 34'(pw_factor) + 34'd32768) >> 16);
        m_amb_q[l] <= pw_side.sh.amb_t[l];
      end
      m_frac_q <= pw_side.sh.frac;
    end
  end

  // stage n: visible fraction applied to both lit terms
  logic              n_v_q;
  logic [DFR_W-1:0]  dfr_q [3];
  logic [SFR_W-1:0]  sfr_q [3];
  logic [E_W-1:0]    n_amb_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        dfr_q[l]   <= DFR_W'((42'(dt_q[l]) * 42'(m_frac_q) + 42'd16384) >> 15);
        sfr_q[l]   <= SFR_W'((34'(sf_q[l]) * 34'(m_frac_q) + 34'd16384) >> 15);
        n_amb_q[l] <= m_amb_q[l];
      end
    end
  end

  // sum and saturate each channel
  logic [2:0][OUT_W-1:0] rgb;

  always_comb begin
    logic [SUM_W-1:0] sum;
    for (int l = 0; l < 3; l++) begin
      sum = SUM_W'(n_amb_q[l]) + SUM_W'(dfr_q[l]) + SUM_W'(sfr_q[l]);
      rgb[l] = (sum > SUM_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : sum[OUT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits travel with the data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      lv_v_q <= 1'b0;
      pr_v_q <= 1'b0;
      ld_v_q <= 1'b0;
      h_v_q  <= 1'b0;
      i_v_q  <= 1'b0;
      j_v_q  <= 1'b0;
      k_v_q  <= 1'b0;
      m_v_q  <= 1'b0;
      n_v_q  <= 1'b0;
    end else if (en) begin
      a_v_q  <= in_if.valid;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      lv_v_q <= dv_v;
      pr_v_q <= lv_v_q;
      ld_v_q <= pr_v_q;
      h_v_q  <= ld_v_q;
      i_v_q  <= h_v_q;
      j_v_q  <= i_v_q;
      k_v_q  <= j_v_q;
      m_v_q  <= pw_v;
      n_v_q  <= m_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output register plus skid register; the pipe keeps taking beats while a
  // finished result waits, until the skid register fills
  // ---------------------------------------------------------------------------
  logic [2:0][OUT_W-1:0] out_q, skid_q;
  logic                  out_take, new_beat;
  logic                  load_out, load_skid, out_from_skid;

  assign out_take      = out_v_q && out_if.ready;
  assign new_beat      = en && n_v_q;
  assign out_from_skid = out_take && skid_v_q;
  assign load_out      = new_beat && (!out_v_q || out_take);
  assign load_skid     = new_beat && out_v_q && !out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_from_skid) begin
        skid_v_q <= 1'b0;
      end else if (load_skid) begin
        skid_v_q <= 1'b1;
      end
      if (out_from_skid || load_out) begin
        out_v_q <= 1'b1;
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= rgb;
    end
    if (load_skid) begin
      skid_q <= rgb;
    end
  end

  assign out_if.valid     = out_v_q;
  assign out_if.out_red   = out_q[0];
  assign out_if.out_green = out_q[1];
  assign out_if.out_blue  = out_q[2];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_skid_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && skid_v_q) |=> (out_v_q && !skid_v_q))
    else $error("skid beat lost on output take");

  a_lit_has_light: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_v_q && !lit_q) |-> (ldn16_q == '0))
    else $error("diffuse dot nonzero on unlit beat");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && k_v_q) |=> (k_v_q && $stable(rde_q)))
    else $error("pipe moved during stall");

endmodule
